FILE: design/utt_pkg.sv
package utt_pkg;

  localparam int unsigned UNIT_W = 16;
  localparam int unsigned CP_W   = 21;

  // surrogate ranges by their top six bits
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
  localparam logic [UNIT_W-1:0] ONE_BYTE_LIMIT = 16'h0080;
  localparam logic [UNIT_W-1:0] TWO_BYTE_LIMIT = 16'h0800;

  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;
  localparam logic [7:0] CONT_MARK  = 8'h80;

  // index of the final byte of a code point (byte count minus one)
  localparam logic [1:0] LEN_1 = 2'd0;
  localparam logic [1:0] LEN_2 = 2'd1;
  localparam logic [1:0] LEN_3 = 2'd2;
  localparam logic [1:0] LEN_4 = 2'd3;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              start_of_string;
  } utt_in_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       last_of_run;
  } utt_out_t;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [1:0]      last_idx;
  } utt_job_t;

endpackage

FILE: design/utt_front.sv
module utt_front #(
  parameter int unsigned MAX_UNITS = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              unit_valid,
  output logic              unit_ready,
  input  utt_pkg::utt_in_t  unit_data,
  output logic              push_valid,
  input  logic              push_ready,
  output utt_pkg::utt_job_t push_job
);

  localparam int unsigned CNT_W = $clog2(MAX_UNITS + 1);

  logic             pending_valid;
  logic             pending_valid_next;
  logic [9:0]       pending_high_bits;
  logic [9:0]       pending_high_bits_next;
  logic [CNT_W-1:0] unit_count;
  logic [CNT_W-1:0] unit_count_next;
  logic             string_ended;
  logic             string_ended_next;

  logic             eff_pend;
  logic [CNT_W-1:0] eff_cnt;
  logic             eff_end;
  logic             blocked;
  logic             has_job;
  logic             accept;
  logic [15:0]      c;

  assign c          = unit_data.code_unit;
  assign unit_ready = push_ready;
  assign accept     = unit_valid && unit_ready;

  // a start flag clears the string state ahead of this unit
  assign eff_pend = pending_valid && !unit_data.start_of_string;
  assign eff_cnt  = unit_data.start_of_string ? '0 : unit_count;
  assign eff_end  = string_ended && !unit_data.start_of_string;
  assign blocked  = eff_end || (eff_cnt >= CNT_W'(MAX_UNITS));

  always_comb begin
    pending_valid_next     = eff_pend;
    pending_high_bits_next = unit_data.start_of_string ? '0 : pending_high_bits;
    unit_count_next        = eff_cnt;
    string_ended_next      = eff_end;
    has_job                = 1'b0;
    push_job.cp            = {5'd0, c};
    push_job.last_idx      = utt_pkg::LEN_3;
    if (!blocked) begin
      unit_count_next    = eff_cnt + 1'b1;
      pending_valid_next = 1'b0;
      if (eff_pend && c[15:10] == utt_pkg::LOW_SURR_TAG) begin
        has_job           = 1'b1;
        push_job.cp       = {1'b0, pending_high_bits, c[9:0]} + utt_pkg::SUPP_BASE;
        push_job.last_idx = utt_pkg::LEN_4;
      end else if (c == '0) begin
        string_ended_next = 1'b1;
      end else if (c < utt_pkg::ONE_BYTE_LIMIT) begin
        has_job           = 1'b1;
        push_job.last_idx = utt_pkg::LEN_1;
      end else if (c < utt_pkg::TWO_BYTE_LIMIT) begin
        has_job           = 1'b1;
        push_job.last_idx = utt_pkg::LEN_2;
      end else if (c[15:10] == utt_pkg::HIGH_SURR_TAG) begin
        pending_valid_next     = 1'b1;
        pending_high_bits_next = c[9:0];
      end else begin
        has_job           = 1'b1;
        push_job.last_idx = utt_pkg::LEN_3;
      end
    end
  end

  assign push_valid = unit_valid && has_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid     <= 1'b0;
      pending_high_bits <= '0;
      unit_count        <= '0;
      string_ended      <= 1'b0;
    end else if (accept) begin
      pending_valid     <= pending_valid_next;
      pending_high_bits <= pending_high_bits_next;
      unit_count        <= unit_count_next;
      string_ended      <= string_ended_next;
    end
  end

endmodule

FILE: design/utt_queue.sv
module utt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  utt_pkg::utt_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output utt_pkg::utt_job_t pop_job
);

  utt_pkg::utt_job_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/utt_back.sv
module utt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  utt_pkg::utt_job_t pop_job,
  output logic              octet_valid,
  input  logic              octet_ready,
  output utt_pkg::utt_out_t octet_data
);

  utt_pkg::utt_job_t cur;
  logic       busy;
  logic [1:0] idx;
  logic       load;
  logic       is_last;
  logic [1:0] remain;
  logic [7:0] byte_val;

  assign load      = busy && (!octet_valid || octet_ready);
  assign is_last   = (idx == cur.last_idx);
  assign pop_ready = !busy || (load && is_last);
  assign remain    = cur.last_idx - idx;

  always_comb begin
    if (idx == 2'd0) begin
      unique case (cur.last_idx)
        utt_pkg::LEN_1: byte_val = {1'b0, cur.cp[6:0]};
        utt_pkg::LEN_2: byte_val = utt_pkg::LEAD2_MARK | {3'd0, cur.cp[10:6]};
        utt_pkg::LEN_3: byte_val = utt_pkg::LEAD3_MARK | {4'd0, cur.cp[15:12]};
        default:        byte_val = utt_pkg::LEAD4_MARK | {5'd0, cur.cp[20:18]};
      endcase
    end else begin
      // continuation bytes carry six bits, highest group first
      case (remain)
        2'd0:    byte_val = utt_pkg::CONT_MARK | {2'd0, cur.cp[5:0]};
        2'd1:    byte_val = utt_pkg::CONT_MARK | {2'd0, cur.cp[11:6]};
        default: byte_val = utt_pkg::CONT_MARK | {2'd0, cur.cp[17:12]};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      octet_data.utf8_byte   <= byte_val;
      octet_data.last_of_run <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      idx         <= '0;
      octet_valid <= 1'b0;
    end else begin
      if (load) begin
        octet_valid <= 1'b1;
      end else if (octet_ready) begin
        octet_valid <= 1'b0;
      end
      if (pop_valid && pop_ready) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (load) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_job;
    end
  end

endmodule

FILE: design/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder. Each request carries one 16-bit code unit and a
// start flag; each result is one UTF-8 byte with last_of_run marking the final
// byte of a code point. A code unit is accepted while the queue has room and
// is classified by the front end, which holds a high surrogate until the next
// unit and drops units after a zero unit or beyond MAX_UNITS units of a string.
// Encoded code points wait in a two-entry queue; the back end sends one byte
// per cycle while octet_ready is high; a unit makes one to four bytes, and the
// byte channel sets sustained throughput. Units that make no bytes (high
// surrogates, terminators, dropped units) are not queued. Output bytes come from
// a register, so units are accepted while a byte waits, until the queue fills.
module utf16_to_utf8_transcoder #(
  parameter int unsigned MAX_UNITS = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              unit_valid,
  output logic              unit_ready,
  input  utt_pkg::utt_in_t  unit_data,
  output logic              octet_valid,
  input  logic              octet_ready,
  output utt_pkg::utt_out_t octet_data
);

  logic              push_valid;
  logic              push_ready;
  utt_pkg::utt_job_t push_job;
  logic              pop_valid;
  logic              pop_ready;
  utt_pkg::utt_job_t pop_job;

  utt_front #(
    .MAX_UNITS(MAX_UNITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .unit_valid (unit_valid),
    .unit_ready (unit_ready),
    .unit_data  (unit_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  utt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  utt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_job     (pop_job),
    .octet_valid (octet_valid),
    .octet_ready (octet_ready),
    .octet_data  (octet_data)
  );

  // a four-byte job always holds a supplementary code point
  a_supp_range: assert property (@(posedge clk) disable iff (rst)
    push_valid && push_job.last_idx == utt_pkg::LEN_4 |->
      push_job.cp >= utt_pkg::SUPP_BASE)
    else $error("four-byte job below supplementary range");

  // a single-byte job is plain ascii
  a_ascii_range: assert property (@(posedge clk) disable iff (rst)
    push_valid && push_job.last_idx == utt_pkg::LEN_1 |->
      push_job.cp < {5'd0, utt_pkg::ONE_BYTE_LIMIT} && push_job.cp != '0)
    else $error("one-byte job out of ascii range");

  // every byte before the last of a code point has its top bit set
  a_non_last_top: assert property (@(posedge clk) disable iff (rst)
    octet_valid && !octet_data.last_of_run |-> octet_data.utf8_byte[7])
    else $error("non-final byte without top bit");

endmodule
